// ----- rtl/wpqe_pkg.sv -----
// Shared types, constants and helpers of the wide polyline quad expander.
`default_nettype none
package wpqe_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 4;
    localparam int OUT_BITS   = 22;
    localparam int W_BITS     = 8;
    localparam int SLOT_BITS  = 3;
    localparam int ABS_BITS   = COORD_BITS;
    localparam int SQ_BITS    = 2 * ABS_BITS + 2;
    localparam int MAG_BITS   = W_BITS + ABS_BITS + FRAC_BITS;
    localparam int M_BITS     = 2 * MAG_BITS;
    localparam int T_BITS     = W_BITS + FRAC_BITS;
    localparam int P_BITS     = M_BITS + 4;
    localparam int Q_BITS     = SQ_BITS + T_BITS + 1;
    localparam int J_BITS     = 4;
    localparam int OFF_BITS   = T_BITS + 2;
    localparam int SUM_BITS   = OUT_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] OUT_MAX = SUM_BITS'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] OUT_MIN = -OUT_MAX - SUM_BITS'(1);

    typedef enum logic [2:0] {
        K_STRIP_PAIR,
        K_STRIP_ONE,
        K_VERT,
        K_HORZ,
        K_DIAG
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        logic signed [COORD_BITS-1:0]  x2;
        logic signed [COORD_BITS-1:0]  y2;
        logic [W_BITS-1:0]             w;
    } t_cmd;

    // Scale a whole-pixel coordinate to fixed point, add the offset and clamp.
    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [COORD_BITS-1:0] pix,
        input logic signed [OFF_BITS-1:0]   off
    );
        logic signed [SUM_BITS-1:0] v;
        v = (SUM_BITS'(pix) <<< FRAC_BITS) + SUM_BITS'(off);
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/wpqe_fifo.sv -----
// Two-entry command queue between the front and the back.
`default_nettype none
module wpqe_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wpqe_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output wpqe_pkg::t_cmd  o_data
);
    import wpqe_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule
`default_nettype wire

// ----- rtl/wpqe_front.sv -----
// Front: takes points, keeps the previous point and the width, classifies segments.
`default_nettype none
module wpqe_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    input  wire  [wpqe_pkg::W_BITS-1:0]           i_line_width,
    input  wire                                   i_accept,
    input  wire  signed [wpqe_pkg::COORD_BITS-1:0] i_pt_x,
    input  wire  signed [wpqe_pkg::COORD_BITS-1:0] i_pt_y,
    input  wire                                   i_new_line,
    output logic                                  o_push,
    output wpqe_pkg::t_cmd                        o_cmd
);
    import wpqe_pkg::*;

    logic [W_BITS-1:0]            r_width;
    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic                         r_prev_valid;
    logic                         r_strip_started;
    logic                         start;
    logic                         strip;

    assign start = i_new_line || !r_prev_valid;
    assign strip = (r_width == W_BITS'(1));
    assign o_push = i_accept && !start;

    always_comb begin
        o_cmd.x1 = r_prev_x;
        o_cmd.y1 = r_prev_y;
        o_cmd.x2 = i_pt_x;
        o_cmd.y2 = i_pt_y;
        o_cmd.w  = r_width;
        if (strip) begin
            o_cmd.kind = r_strip_started ? K_STRIP_ONE : K_STRIP_PAIR;
        end else if (r_prev_x == i_pt_x) begin
            o_cmd.kind = K_VERT;
        end else if (r_prev_y == i_pt_y) begin
            o_cmd.kind = K_HORZ;
        end else begin
            o_cmd.kind = K_DIAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width         <= W_BITS'(1);
            r_prev_x        <= '0;
            r_prev_y        <= '0;
            r_prev_valid    <= 1'b0;
            r_strip_started <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_line_width;
            end
            if (i_accept) begin
                r_prev_x        <= i_pt_x;
                r_prev_y        <= i_pt_y;
                r_prev_valid    <= 1'b1;
                r_strip_started <= !start && strip;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/wpqe_back.sv -----
// Back: works out the offsets of a segment and sends its vertices out.
`default_nettype none
module wpqe_back (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cmd_valid,
    input  wpqe_pkg::t_cmd                         i_cmd,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [wpqe_pkg::OUT_BITS-1:0]   o_vert_x,
    output logic signed [wpqe_pkg::OUT_BITS-1:0]   o_vert_y,
    output logic [wpqe_pkg::SLOT_BITS-1:0]         o_vert_slot,
    output logic                                   o_last_vert
);
    import wpqe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ABS  = 6'b000010,
        S_SQR  = 6'b000100,
        S_MAG2 = 6'b001000,
        S_ITER = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    t_cmd                        r_cmd;
    logic [ABS_BITS-1:0]         r_ad   [2];
    logic [MAG_BITS-1:0]         r_mag  [2];
    logic [P_BITS-1:0]           r_m    [2];
    logic [P_BITS-1:0]           r_p    [2];
    logic [P_BITS-1:0]           n_p    [2];
    logic [Q_BITS-1:0]           r_q    [2];
    logic [Q_BITS-1:0]           n_q    [2];
    logic [T_BITS-1:0]           r_t    [2];
    logic [T_BITS-1:0]           n_t    [2];
    logic [SQ_BITS-1:0]          r_s;
    logic                        r_neg;
    logic [J_BITS-1:0]           r_j;
    logic signed [OFF_BITS-1:0]  r_offx, r_offy;
    logic signed [OFF_BITS-1:0]  idle_offx, idle_offy, iter_offx, iter_offy;
    logic [SLOT_BITS-1:0]        r_cnt;
    logic                        r_ovalid;
    logic                        load;
    logic                        is_strip;
    logic                        v_last;
    logic                        v_p2;
    logic                        v_neg;
    logic signed [OFF_BITS-1:0]  v_ox, v_oy;
    logic signed [COORD_BITS:0]  dxs, dys;
    logic signed [OFF_BITS-1:0]  h16;
    logic [4:0]                  sh1, sh2;
    logic [P_BITS-1:0]           trial [2];
    logic [T_BITS:0]             qsum  [2];

    assign o_pop   = r_state[0] && i_cmd_valid;
    assign o_valid = r_ovalid;
    assign is_strip = (r_cmd.kind == K_STRIP_PAIR) || (r_cmd.kind == K_STRIP_ONE);

    // Half width in fixed point for axis-aligned segments.
    assign h16 = OFF_BITS'(i_cmd.w >> 1) <<< FRAC_BITS;

    always_comb begin
        idle_offx = '0;
        idle_offy = '0;
        case (i_cmd.kind)
            K_VERT:  idle_offx = -h16;
            K_HORZ:  idle_offy = h16;
            default: begin
                idle_offx = '0;
                idle_offy = '0;
            end
        endcase
    end

    assign dxs = 17'(r_cmd.x1) - 17'(r_cmd.x2);
    assign dys = 17'(r_cmd.y2) - 17'(r_cmd.y1);

    // One bit of floor(mag / sqrt(s)) per cycle for each lane, MSB first.
    assign sh1 = 5'(r_j) + 5'd1;
    assign sh2 = {r_j, 1'b0};
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            trial[i] = r_p[i] + (P_BITS'(r_q[i]) << sh1) + (P_BITS'(r_s) << sh2);
            if (trial[i] <= r_m[i]) begin
                n_p[i] = trial[i];
                n_q[i] = r_q[i] + (Q_BITS'(r_s) << r_j);
                n_t[i] = r_t[i] | (T_BITS'(1) << r_j);
            end else begin
                n_p[i] = r_p[i];
                n_q[i] = r_q[i];
                n_t[i] = r_t[i];
            end
            qsum[i] = ((T_BITS + 1)'(n_t[i]) + (T_BITS + 1)'(1)) >> 1;
        end
        iter_offy = OFF_BITS'(qsum[0]);
        iter_offx = r_neg ? -OFF_BITS'(qsum[1]) : OFF_BITS'(qsum[1]);
    end

    // Vertex order within the quad: v1, v2, v3, v3, v2, v4.
    always_comb begin
        if (is_strip) begin
            v_p2   = (r_cnt != SLOT_BITS'(0));
            v_neg  = 1'b0;
            v_last = (r_cnt == SLOT_BITS'(1));
        end else begin
            v_p2   = (r_cnt == SLOT_BITS'(2)) || (r_cnt == SLOT_BITS'(3))
                  || (r_cnt == SLOT_BITS'(5));
            v_neg  = (r_cnt == SLOT_BITS'(1)) || (r_cnt == SLOT_BITS'(4))
                  || (r_cnt == SLOT_BITS'(5));
            v_last = (r_cnt == SLOT_BITS'(5));
        end
        v_ox = v_neg ? -r_offx : r_offx;
        v_oy = v_neg ? -r_offy : r_offy;
    end

    assign load = r_state[5] && (!r_ovalid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == K_DIAG) ? S_ABS : S_EMIT;
                end
            end
            S_ABS:  n_state = S_SQR;
            S_SQR:  n_state = S_MAG2;
            S_MAG2: n_state = S_ITER;
            S_ITER: begin
                if (r_j == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load && v_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= load || (r_ovalid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_offx <= idle_offx;
                r_offy <= idle_offy;
                r_cnt  <= (i_cmd.kind == K_STRIP_ONE) ? SLOT_BITS'(1) : SLOT_BITS'(0);
            end
            S_ABS: begin
                r_ad[0] <= ABS_BITS'(dxs < 0 ? -dxs : dxs);
                r_ad[1] <= ABS_BITS'(dys < 0 ? -dys : dys);
                r_neg   <= (dxs < 0) != (dys < 0);
            end
            S_SQR: begin
                r_s <= SQ_BITS'(r_ad[0] * r_ad[0]) + SQ_BITS'(r_ad[1] * r_ad[1]);
                for (int i = 0; i < 2; i++) begin
                    r_mag[i] <= MAG_BITS'(r_cmd.w * r_ad[i]) << FRAC_BITS;
                end
            end
            S_MAG2: begin
                for (int i = 0; i < 2; i++) begin
                    r_m[i] <= P_BITS'(r_mag[i] * r_mag[i]);
                    r_p[i] <= '0;
                    r_q[i] <= '0;
                    r_t[i] <= '0;
                end
                r_j <= J_BITS'(T_BITS - 1);
            end
            S_ITER: begin
                for (int i = 0; i < 2; i++) begin
                    r_p[i] <= n_p[i];
                    r_q[i] <= n_q[i];
                    r_t[i] <= n_t[i];
                end
                r_j <= r_j - J_BITS'(1);
                if (r_j == '0) begin
                    r_offx <= iter_offx;
                    r_offy <= iter_offy;
                end
            end
            S_EMIT: begin
                if (load) begin
                    r_cnt <= r_cnt + SLOT_BITS'(1);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_vert_x    <= sat_out(v_p2 ? r_cmd.x2 : r_cmd.x1, v_ox);
            o_vert_y    <= sat_out(v_p2 ? r_cmd.y2 : r_cmd.y1, v_oy);
            o_vert_slot <= is_strip ? SLOT_BITS'(0) : r_cnt;
            o_last_vert <= v_last;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vert_slot <= SLOT_BITS'(5)))
        else $error("vertex slot out of range");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ITER |-> (r_p[0] <= r_m[0]) && (r_p[1] <= r_m[1]))
        else $error("square root search overshoot");
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && v_last |=> r_state == S_IDLE && o_last_vert)
        else $error("last vertex did not end the segment");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != S_IDLE)
        else $error("command taken without starting work");
endmodule
`default_nettype wire

// ----- rtl/wide_polyline_quad_expander_unit.sv -----
// Start-of-line points make no vertices; a strip vertex passes the queue, the back's command
// register and the output register. Axis-aligned wide segments take that path, then give one
// vertex a cycle while i_ready holds. Other wide segments: offset work (queue pop, 3 set-up
// steps, then a 12-step bit-serial square root search for both axes at once), then 6 vertices.
// A two-entry command queue lets points be taken while a segment is expanded.
// Synchronous active-low reset: no previous point, line width 1, queue and output empty.
`default_nettype none
module wide_polyline_quad_expander_unit (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [wpqe_pkg::W_BITS-1:0]            i_line_width,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire  signed [wpqe_pkg::COORD_BITS-1:0] i_pt_x,
    input  wire  signed [wpqe_pkg::COORD_BITS-1:0] i_pt_y,
    input  wire                                    i_new_line,
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [wpqe_pkg::OUT_BITS-1:0]   o_vert_x,
    output logic signed [wpqe_pkg::OUT_BITS-1:0]   o_vert_y,
    output logic [wpqe_pkg::SLOT_BITS-1:0]         o_vert_slot,
    output logic                                   o_last_vert
);
    import wpqe_pkg::*;

    logic full, push, pop, cmd_valid;
    t_cmd front_cmd, back_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !full;

    wpqe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_line_width (i_line_width),
        .i_accept     (i_valid && !full),
        .i_pt_x       (i_pt_x),
        .i_pt_y       (i_pt_y),
        .i_new_line   (i_new_line),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    wpqe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .i_pop   (pop),
        .o_data  (back_cmd)
    );

    wpqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_vert_x    (o_vert_x),
        .o_vert_y    (o_vert_y),
        .o_vert_slot (o_vert_slot),
        .o_last_vert (o_last_vert)
    );
endmodule
`default_nettype wire
